FILE: hw/rtl/look_disk_scheduler_defines.svh
// Assertion macros for the LOOK disk scheduler.
// Included by the top level; depends on nothing else.
`ifndef LOOK_DISK_SCHEDULER_DEFINES_SVH
`define LOOK_DISK_SCHEDULER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define LDS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define LDS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define LDS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg)
`define LDS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

FILE: hw/rtl/lds_pkg.sv
// Shared types and constants of the LOOK disk scheduler.
// Used by the interfaces, the controller, the datapath and the top level.
package lds_pkg;

  localparam int CYL_W = 16;
  localparam int SUM_W = 24;

  typedef enum logic {
    OP_ADD   = 1'b0,
    OP_START = 1'b1
  } lds_op_t;

  typedef struct packed {
    logic load;
    logic start;
    logic scan_first;
    logic scan_next;
    logic emit;
    logic emit_empty;
    logic finish;
  } lds_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic scan_last;
    logic run_last;
  } lds_sts_t;

endpackage

FILE: hw/rtl/lds_if.sv
// Valid/ready channel interfaces for request beats and result beats.
// Depends on lds_pkg for the field widths.
interface lds_in_if import lds_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             operation;
  logic [CYL_W-1:0] cylinder;
  logic [CYL_W-1:0] previous_cylinder;

  modport source (output valid, output operation, output cylinder,
                  output previous_cylinder, input ready);
  modport sink (input valid, input operation, input cylinder,
                input previous_cylinder, output ready);
endinterface

interface lds_out_if import lds_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CYL_W-1:0] served_cylinder;
  logic [CYL_W-1:0] seek_distance;
  logic [SUM_W-1:0] total_distance;
  logic             empty_table;
  logic             last;

  modport source (output valid, output served_cylinder, output seek_distance,
                  output total_distance, output empty_table, output last,
                  input ready);
  modport sink (input valid, input served_cylinder, input seek_distance,
                input total_distance, input empty_table, input last,
                output ready);
endinterface

FILE: hw/rtl/lds_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lds_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: hw/rtl/lds_ctrl.sv
// Controller of the LOOK disk scheduler: sequences loads, table scans and result beats.
// Depends on lds_pkg for the command and status structs.
module lds_ctrl import lds_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_operation,
  output logic     in_ready,
  input  logic     out_ready,
  output logic     out_valid,
  input  lds_sts_t sts,
  output lds_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_EMIT,
    S_EMPTY
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (lds_op_t'(in_operation) == OP_ADD) begin
            cmd.load = 1'b1;
          end else begin
            cmd.start = 1'b1;
            if (sts.count_zero) begin
              state_nxt = S_EMPTY;
            end else begin
              cmd.scan_first = 1'b1;
              state_nxt      = S_SCAN;
            end
          end
        end
      end
      S_SCAN: begin
        if (sts.scan_last) begin
          state_nxt = S_EMIT;
        end else begin
          cmd.scan_next = 1'b1;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
          if (sts.run_last) begin
            cmd.finish = 1'b1;
            state_nxt  = S_IDLE;
          end else begin
            cmd.scan_first = 1'b1;
            state_nxt      = S_SCAN;
          end
        end
      end
      S_EMPTY: begin
        if (out_free) begin
          cmd.emit_empty = 1'b1;
          out_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: hw/rtl/lds_dp.sv
// Datapath of the LOOK disk scheduler: request table, served marks, scan and result registers.
// Depends on lds_pkg and lds_ram.
module lds_dp import lds_pkg::*; #(
  parameter int MAX_REQUESTS = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  lds_cmd_t         cmd,
  output lds_sts_t         sts,
  input  logic [CYL_W-1:0] in_cylinder,
  input  logic [CYL_W-1:0] in_previous_cylinder,
  output logic [CYL_W-1:0] out_served_cylinder,
  output logic [CYL_W-1:0] out_seek_distance,
  output logic [SUM_W-1:0] out_total_distance,
  output logic             out_empty_table,
  output logic             out_last
);

  localparam int IDX_W = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
  localparam int CNT_W = $clog2(MAX_REQUESTS + 1);

  logic [CNT_W-1:0]        count_r;
  logic [CNT_W-1:0]        served_r;
  logic [CNT_W-1:0]        count_m1;
  logic [CYL_W-1:0]        head_r;
  logic [SUM_W-1:0]        sum_r;
  logic                    up_r;
  logic [IDX_W-1:0]        addr_r;
  logic                    rd_pend_r;
  logic [IDX_W-1:0]        rd_idx_r;
  logic [MAX_REQUESTS-1:0] marks_r;

  logic                    up_found_r, dn_found_r;
  logic [CYL_W-1:0]        up_d_r, dn_d_r;
  logic [CYL_W-1:0]        up_c_r, dn_c_r;
  logic [IDX_W-1:0]        up_idx_r, dn_idx_r;

  logic [CYL_W-1:0]        res_cyl_r, res_dist_r;
  logic [SUM_W-1:0]        res_sum_r;
  logic                    res_empty_r, res_last_r;

  logic                    full;
  logic                    ram_we, ram_re;
  logic [IDX_W-1:0]        ram_raddr;
  logic [CYL_W-1:0]        ram_rdata;
  logic                    eval;
  logic [CYL_W-1:0]        d_up, d_dn;
  logic                    upd_up, upd_dn;
  logic                    pick_up;
  logic [CYL_W-1:0]        pick_c, pick_d;
  logic [IDX_W-1:0]        pick_idx;
  logic [SUM_W-1:0]        sum_new;

  assign full      = (count_r == CNT_W'(MAX_REQUESTS));
  assign count_m1  = count_r - CNT_W'(1);
  assign ram_we    = cmd.load && !full;
  assign ram_re    = cmd.scan_first || cmd.scan_next;
  assign ram_raddr = cmd.scan_next ? (addr_r + IDX_W'(1)) : '0;

  lds_ram #(
    .WIDTH(CYL_W),
    .DEPTH(MAX_REQUESTS)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(count_r[IDX_W-1:0]),
    .wdata(in_cylinder),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign eval   = rd_pend_r && !marks_r[rd_idx_r];
  assign d_up   = ram_rdata - head_r;
  assign d_dn   = head_r - ram_rdata;
  assign upd_up = eval && (ram_rdata >= head_r) && (!up_found_r || (d_up < up_d_r));
  assign upd_dn = eval && (ram_rdata <= head_r) && (!dn_found_r || (d_dn < dn_d_r));

  assign pick_up  = (up_r && up_found_r) || (!up_r && !dn_found_r);
  assign pick_c   = pick_up ? up_c_r : dn_c_r;
  assign pick_d   = pick_up ? up_d_r : dn_d_r;
  assign pick_idx = pick_up ? up_idx_r : dn_idx_r;
  assign sum_new  = sum_r + SUM_W'(pick_d);

  assign sts.count_zero = (count_r == '0);
  assign sts.scan_last  = (CNT_W'(addr_r) == count_m1);
  assign sts.run_last   = (served_r == count_m1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      served_r   <= '0;
      head_r     <= '0;
      sum_r      <= '0;
      up_r       <= 1'b1;
      rd_pend_r  <= 1'b0;
      marks_r    <= '0;
      up_found_r <= 1'b0;
      dn_found_r <= 1'b0;
    end else begin
      rd_pend_r <= ram_re;
      if (ram_we) begin
        count_r <= count_r + CNT_W'(1);
      end
      if (cmd.start) begin
        head_r   <= in_cylinder;
        sum_r    <= '0;
        up_r     <= !(in_cylinder < in_previous_cylinder);
        served_r <= '0;
      end
      if (cmd.scan_first) begin
        up_found_r <= 1'b0;
        dn_found_r <= 1'b0;
      end else begin
        if (upd_up) begin
          up_found_r <= 1'b1;
        end
        if (upd_dn) begin
          dn_found_r <= 1'b1;
        end
      end
      if (cmd.emit) begin
        head_r   <= pick_c;
        sum_r    <= sum_new;
        up_r     <= pick_up;
        served_r <= served_r + CNT_W'(1);
      end
      if (cmd.finish) begin
        marks_r <= '0;
        count_r <= '0;
      end else if (cmd.emit) begin
        marks_r[pick_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ram_re) begin
      addr_r   <= ram_raddr;
      rd_idx_r <= ram_raddr;
    end
    if (upd_up) begin
      up_d_r   <= d_up;
      up_c_r   <= ram_rdata;
      up_idx_r <= rd_idx_r;
    end
    if (upd_dn) begin
      dn_d_r   <= d_dn;
      dn_c_r   <= ram_rdata;
      dn_idx_r <= rd_idx_r;
    end
    if (cmd.emit) begin
      res_cyl_r   <= pick_c;
      res_dist_r  <= pick_d;
      res_sum_r   <= sum_new;
      res_empty_r <= 1'b0;
      res_last_r  <= sts.run_last;
    end else if (cmd.emit_empty) begin
      res_cyl_r   <= '0;
      res_dist_r  <= '0;
      res_sum_r   <= '0;
      res_empty_r <= 1'b1;
      res_last_r  <= 1'b1;
    end
  end

  assign out_served_cylinder = res_cyl_r;
  assign out_seek_distance   = res_dist_r;
  assign out_total_distance  = res_sum_r;
  assign out_empty_table     = res_empty_r;
  assign out_last            = res_last_r;

endmodule

FILE: hw/rtl/look_disk_scheduler.sv
// LOOK disk scheduler. An add beat stores its cylinder in the request table (dropped when
// the table is full). A start beat with n pending requests yields n result beats; for
// each one, every entry of the request table RAM is read in turn, and the pick is then
// committed once the output is free. A start on an empty table yields one empty result.
// Input beats are taken only between runs; the last result may still be waiting on the
// output while the next beat is accepted.
// Depends on lds_pkg, lds_if, lds_ctrl, lds_dp, lds_ram and look_disk_scheduler_defines.svh.
`include "look_disk_scheduler_defines.svh"

module look_disk_scheduler import lds_pkg::*; #(
  parameter int MAX_REQUESTS = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  lds_in_if.sink    in_ch,
  lds_out_if.source out_ch
);

  lds_cmd_t cmd;
  lds_sts_t sts;
  logic     in_ready;
  logic     out_valid;

  lds_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_operation(in_ch.operation),
    .in_ready    (in_ready),
    .out_ready   (out_ch.ready),
    .out_valid   (out_valid),
    .sts         (sts),
    .cmd         (cmd)
  );

  lds_dp #(
    .MAX_REQUESTS(MAX_REQUESTS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_cylinder         (in_ch.cylinder),
    .in_previous_cylinder(in_ch.previous_cylinder),
    .out_served_cylinder (out_ch.served_cylinder),
    .out_seek_distance   (out_ch.seek_distance),
    .out_total_distance  (out_ch.total_distance),
    .out_empty_table     (out_ch.empty_table),
    .out_last            (out_ch.last)
  );

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;

  `LDS_ASSERT_NOW(a_no_input_in_run, clk, rst_n, cmd.emit || cmd.scan_next, !in_ready, "Input ready during a run.")
  `LDS_ASSERT_NOW(a_no_overwrite, clk, rst_n, cmd.emit || cmd.emit_empty, !out_valid || out_ch.ready, "Result overwritten before it was taken.")
  `LDS_ASSERT_NEXT(a_table_emptied, clk, rst_n, cmd.finish, sts.count_zero && in_ready, "Table not emptied after a run.")

endmodule
